FILE: design/nbd_pkg.sv
// nbd_pkg: types and constants for the nibble dequantiser
// no dependencies
package nbd_pkg;

  localparam int LANES = 8;
  localparam int NIB_W = 4;
  localparam int BF_W  = 16;

  localparam logic [15:0] BF_QNAN = 16'h7FC0;
  localparam logic [15:0] BF_INF  = 16'h7F80;
  localparam logic [7:0]  EXP_MAX = 8'hFF;

  typedef struct packed {
    logic        last_in;
    logic [15:0] scale_bits;
    logic [31:0] packed_nibbles;
  } nbd_in_t;

  typedef struct packed {
    logic        last_out;
    logic [15:0] value_7;
    logic [15:0] value_6;
    logic [15:0] value_5;
    logic [15:0] value_4;
    logic [15:0] value_3;
    logic [15:0] value_2;
    logic [15:0] value_1;
    logic [15:0] value_0;
  } nbd_out_t;

  typedef logic [BF_W-1:0] bf16_t;

endpackage

FILE: design/nbd_lane.sv
// nbd_lane: one lane, 4-bit nibble times bfloat16 scale, rounded to bfloat16
// depends on nbd_pkg
module nbd_lane (
  input  logic [nbd_pkg::NIB_W-1:0] nib,
  input  logic [15:0]               scale,
  output nbd_pkg::bf16_t            value
);
  logic        sign;
  logic [7:0]  ex;
  logic [6:0]  fr;
  logic [11:0] p;
  logic [2:0]  sh;
  logic [7:0]  sig;
  logic [8:0]  sig_r;
  logic [3:0]  rem;
  logic        up;
  logic [9:0]  e;
  logic [9:0]  e_f;
  logic [7:0]  sig_f;

  always_comb begin
    sign = scale[15];
    ex   = scale[14:7];
    fr   = scale[6:0];
    p    = 12'(nib) * 12'({1'b1, fr});
    // leading one position above bit 7
    if (p[11])      sh = 3'd4;
    else if (p[10]) sh = 3'd3;
    else if (p[9])  sh = 3'd2;
    else if (p[8])  sh = 3'd1;
    else            sh = 3'd0;
    sig = 8'(p >> sh);
    rem = 4'(p & ((12'd1 << sh) - 12'd1));
    up  = 1'b0;
    case (sh)
      3'd1: up = rem[0] && sig[0];
      3'd2: up = rem[1] && (rem[0] || sig[0]);
      3'd3: up = rem[2] && ((rem[1:0] != 2'd0) || sig[0]);
      3'd4: up = rem[3] && ((rem[2:0] != 3'd0) || sig[0]);
      default: up = 1'b0;
    endcase
    sig_r = {1'b0, sig} + 9'(up);
    e     = 10'(ex) + 10'(sh);
    // rounding carry renormalises
    if (sig_r[8]) begin
      sig_f = sig_r[8:1];
      e_f   = e + 10'd1;
    end else begin
      sig_f = sig_r[7:0];
      e_f   = e;
    end
    // special cases first
    if (ex == nbd_pkg::EXP_MAX) begin
      if (fr != 7'd0 || nib == '0) value = nbd_pkg::BF_QNAN;
      else                          value = nbd_pkg::BF_INF | {sign, 15'd0};
    end else if (ex == 8'd0 || nib == '0) begin
      value = {sign, 15'd0};
    end else if (e_f >= 10'(nbd_pkg::EXP_MAX)) begin
      value = nbd_pkg::BF_INF | {sign, 15'd0};
    end else begin
      value = {sign, e_f[7:0], sig_f[6:0]};
    end
  end
endmodule

FILE: design/nibble_to_bf16_dequantizer.sv
// nibble_to_bf16_dequantizer: top level, eight lanes and a merging output register
// depends on nbd_pkg and nbd_lane
//
//  port        dir  handshake          payload
//  in_*        in   in_valid/in_stall  nbd_in_t  (nibbles, scale, last)
//  out_*       out  out_valid/out_stall nbd_out_t (eight values, last)
//
// one word per cycle while the output does not stall; each result is held in the output register
// lanes are purely combinational, one 4x8 multiply and a round each
// a second (skid) register holds a word taken while the output stalls
// reset clears both valid flags; payload registers are not reset
module nibble_to_bf16_dequantizer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  nbd_pkg::nbd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output nbd_pkg::nbd_out_t out_data
);
  nbd_pkg::bf16_t    lane_val [nbd_pkg::LANES];
  nbd_pkg::nbd_out_t merged;
  nbd_pkg::nbd_out_t skid;
  logic              skid_valid;
  logic              in_acc;

  // lane array
  for (genvar k = 0; k < nbd_pkg::LANES; k++) begin : g_lane
    nbd_lane u_lane (
      .nib   (in_data.packed_nibbles[nbd_pkg::NIB_W*k +: nbd_pkg::NIB_W]),
      .scale (in_data.scale_bits),
      .value (lane_val[k])
    );
  end

  // merge lane results into one transaction
  always_comb begin
    merged.value_0  = lane_val[0];
    merged.value_1  = lane_val[1];
    merged.value_2  = lane_val[2];
    merged.value_3  = lane_val[3];
    merged.value_4  = lane_val[4];
    merged.value_5  = lane_val[5];
    merged.value_6  = lane_val[6];
    merged.value_7  = lane_val[7];
    merged.last_out = in_data.last_in;
  end

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !in_stall;

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        if (skid_valid) begin
          out_data   <= skid;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_acc;
          if (in_acc) out_data <= merged;
        end
      end else if (in_acc) begin
        skid       <= merged;
        skid_valid <= 1'b1;
      end
    end
  end

  // checks
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");
  a_skid: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid full with empty output");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    in_acc && !out_valid && !skid_valid |=> out_valid && !skid_valid)
    else $error("accepted word lost");
endmodule

FILE: dv/nbd_checker.sv
// nbd_checker: watches both channels of the nibble dequantiser, predicts each result
// depends on nbd_pkg
`timescale 1ns / 1ps
module nbd_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  nbd_pkg::nbd_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  nbd_pkg::nbd_out_t out_data,
  output int                fail_count,
  output int                pending_count
);
  nbd_pkg::nbd_out_t expected_words[$];

  // one lane: nibble times bf16 scale, rounded to nearest even
  function automatic nbd_pkg::bf16_t lane_product(logic [3:0] nib, nbd_pkg::bf16_t sc);
    logic        sgn;
    logic [7:0]  ex;
    logic [6:0]  fr;
    logic [11:0] prod;
    int          top;
    int          sh;
    logic [11:0] rem;
    logic [11:0] half;
    logic [8:0]  sig;
    int          e;
    sgn = sc[15];
    ex  = sc[14:7];
    fr  = sc[6:0];
    if (ex == nbd_pkg::EXP_MAX) begin
      if (fr != 0 || nib == 0) return nbd_pkg::BF_QNAN;
      return {sgn, nbd_pkg::BF_INF[14:0]};
    end
    if (ex == 0 || nib == 0) return {sgn, 15'd0};
    prod = 12'(nib) * 12'({1'b1, fr});
    top = 7;
    while (top < 11 && (prod >> (top + 1)) != 0) top++;
    sh  = top - 7;
    sig = 9'(prod >> sh);
    if (sh > 0) begin
      rem  = prod & ((12'd1 << sh) - 12'd1);
      half = 12'd1 << (sh - 1);
      if (rem > half || (rem == half && sig[0])) sig++;
    end
    e = ex + sh;
    if (sig >= 9'h100) begin
      sig = sig >> 1;
      e++;
    end
    if (e >= 255) return {sgn, nbd_pkg::BF_INF[14:0]};
    return {sgn, e[7:0], sig[6:0]};
  endfunction

  function automatic nbd_pkg::nbd_out_t dequant_word(nbd_pkg::nbd_in_t w);
    nbd_pkg::nbd_out_t r;
    r.value_0  = lane_product(w.packed_nibbles[3:0],   w.scale_bits);
    r.value_1  = lane_product(w.packed_nibbles[7:4],   w.scale_bits);
    r.value_2  = lane_product(w.packed_nibbles[11:8],  w.scale_bits);
    r.value_3  = lane_product(w.packed_nibbles[15:12], w.scale_bits);
    r.value_4  = lane_product(w.packed_nibbles[19:16], w.scale_bits);
    r.value_5  = lane_product(w.packed_nibbles[23:20], w.scale_bits);
    r.value_6  = lane_product(w.packed_nibbles[27:24], w.scale_bits);
    r.value_7  = lane_product(w.packed_nibbles[31:28], w.scale_bits);
    r.last_out = w.last_in;
    return r;
  endfunction

  assign pending_count = expected_words.size();

  // predict on input transaction, compare on output transaction
  always @(posedge clk) begin
    nbd_pkg::nbd_out_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) expected_words.push_back(dequant_word(in_data));
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (want !== out_data) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: dv/testbench.sv
// testbench: stimulus, stall patterns and verdict for nibble_to_bf16_dequantizer
// depends on nbd_pkg, the block and nbd_checker
`timescale 1ns / 1ps
module testbench;
  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  nbd_pkg::nbd_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  nbd_pkg::nbd_out_t out_data;
  int                fail_count;
  int                pending_count;
  bit                hold_off_done;

  nibble_to_bf16_dequantizer u_dut (.*);

  nbd_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [15:0] rand_scale();
    case ($urandom_range(0, 9))
      0: return {$urandom_range(0, 1) == 1, 8'hFF, 7'($urandom)};
      1: return {$urandom_range(0, 1) == 1, 8'h00, 7'($urandom)};
      2: return {$urandom_range(0, 1) == 1, 8'($urandom_range(250, 254)), 7'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  // present one transaction and wait for it to be taken
  task automatic send_word(logic [31:0] nibs, logic [15:0] sc, logic lst);
    in_valid <= 1;
    in_data  <= '{last_in: lst, scale_bits: sc, packed_nibbles: nibs};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 0;
    repeat (n) @(negedge clk);
  endtask

  // receiver stall pattern, with one long hold-off
  initial begin
    out_stall = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    repeat (40) @(negedge clk);
    out_stall <= 1;
    repeat (60) @(negedge clk);
    hold_off_done = 1;
    forever begin
      case ($urandom_range(0, 3))
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= ($urandom_range(0, 4) != 0);
      endcase
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  initial begin
    logic [15:0] dir_scales[12];
    int wait_cycles;
    int burst;
    dir_scales = '{16'h3F80, 16'hBF80, 16'h7F7F, 16'h7F80, 16'hFF80, 16'h7FC0,
                   16'h0001, 16'h8000, 16'h0000, 16'h3FFF, 16'hFFFF, 16'h4300};
    rst = 1;
    in_valid = 0;
    in_data = '0;
    repeat (9) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed words: extremes of nibbles and special scales
    foreach (dir_scales[i]) send_word(32'hFEDC_BA90, dir_scales[i], i[0]);
    send_word(32'hFFFF_FFFF, 16'h7F7F, 1);
    send_word(32'h0000_0000, 16'hFF7F, 0);
    send_word(32'h8888_8888, 16'h4321, 1);
    send_word(32'h1357_9BDF, 16'h3F81, 0);
    // keep offering while the receiver holds off so the block fills
    while (!hold_off_done) send_word($urandom, rand_scale(), 1'($urandom_range(0, 1)));
    // random bursts with gaps
    for (int n = 0; n < 1100; n += burst) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst; j++) begin
        send_word($urandom, rand_scale(), 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    in_valid <= 0;
    wait_cycles = 0;
    while (pending_count != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

FILE: nibble_to_bf16_dequantizer.f
design/nbd_pkg.sv
design/nbd_lane.sv
design/nibble_to_bf16_dequantizer.sv
dv/nbd_checker.sv
dv/testbench.sv
